>>> hdl/plc_pkg.sv
package plc_pkg;

  localparam int PLC_CAP_DEF = 64;
  localparam int PLC_CAP_MAX = 1024;
  // wide enough for any index or count up to the largest store
  localparam int PLC_IDX_W = $clog2(PLC_CAP_MAX + 1);
  localparam int PLC_VAL_W = 32;
  localparam int PLC_POS_W = 7;
  localparam int PLC_LEN_W = 7;
  localparam int PLC_ST_W = 2;

  localparam logic [PLC_ST_W-1:0] PLC_ST_DONE  = 2'd0;
  localparam logic [PLC_ST_W-1:0] PLC_ST_FULL  = 2'd1;
  localparam logic [PLC_ST_W-1:0] PLC_ST_RANGE = 2'd2;

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_END   = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_END   = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_REVERSE   = 3'd6,
    CMD_READ      = 3'd7
  } plc_cmd_t;

  typedef struct packed {
    plc_cmd_t                     command;
    logic signed [PLC_VAL_W-1:0]  value;
    logic        [PLC_POS_W-1:0]  position;
  } plc_in_t;

  typedef struct packed {
    logic        [PLC_ST_W-1:0]   status;
    logic        [PLC_LEN_W-1:0]  length;
    logic signed [PLC_VAL_W-1:0]  read_value;
  } plc_out_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                         ins;
    logic                         del;
    logic                         rd_load;
    logic                         rd_shift;
    logic        [PLC_IDX_W-1:0]  target;
    logic signed [PLC_VAL_W-1:0]  value;
  } plc_cell_ctl_t;

endpackage

>>> hdl/positional_list_engine.sv
// Ordered list of up to CAPACITY signed 32-bit words kept in a row of cells. Insert and delete
// shift the cells above the target position by one, and reverse only flips a direction flag,
// so position p lives in cell p, or in cell length-1-p after an odd number of reverses. Every
// command except an in-range read is answered as soon as it is accepted. An in-range read
// snapshots the row onto a read bus that moves one cell per cycle toward cell zero, walking
// from the cell that holds the element (0 to CAPACITY-1) down to cell zero; no new word is
// taken during that walk. Results pass through a two-word output buffer, so one more command
// is accepted while a finished result waits. No clearing pass after reset.
module positional_list_engine #(
  parameter int CAPACITY = plc_pkg::PLC_CAP_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  plc_pkg::plc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output plc_pkg::plc_out_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int XW = plc_pkg::PLC_IDX_W;
  localparam int VW = plc_pkg::PLC_VAL_W;

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              rev_r, rev_nxt;
  logic [IW-1:0]     rd_cnt_r, rd_cnt_nxt;
  logic              o0_valid_r, o0_valid_nxt;
  logic              o1_valid_r, o1_valid_nxt;
  plc_pkg::plc_out_t o0_r, o0_nxt;
  plc_pkg::plc_out_t o1_r, o1_nxt;

  plc_pkg::plc_cell_ctl_t ctl;
  plc_pkg::plc_out_t      res;
  logic                   done;
  logic                   accept;
  logic                   take;
  logic                   full;
  logic                   inb;
  logic                   is_ins, is_del, is_rev, is_rd;
  logic [XW-1:0]          nx, px, lpos, phys_ins, phys_hit, new_len;

  logic signed [VW-1:0] dat  [CAPACITY];
  logic signed [VW-1:0] rbus [CAPACITY];

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic signed [VW-1:0] left_w, right_w, rright_w;
      if (gi == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_mid
        assign left_w = dat[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right_w  = '0;
        assign rright_w = '0;
      end else begin : g_body
        assign right_w  = dat[gi+1];
        assign rright_w = rbus[gi+1];
      end
      plc_cell #(.INDEX(gi)) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .left_dat   (left_w),
        .right_dat  (right_w),
        .right_rbus (rright_w),
        .dat        (dat[gi]),
        .rbus       (rbus[gi])
      );
    end
  endgenerate

  assign in_stall  = (state_r != S_IDLE) || o1_valid_r;
  assign accept    = in_valid && !in_stall;
  assign take      = o0_valid_r && !out_stall;
  assign out_valid = o0_valid_r;
  assign out_data  = o0_r;

  // decode and position mapping
  always_comb begin
    nx     = XW'(cnt_r);
    px     = XW'(in_data.position);
    full   = (cnt_r == CW'(CAPACITY));
    is_ins = 1'b0;
    is_del = 1'b0;
    is_rev = 1'b0;
    is_rd  = 1'b0;
    lpos   = '0;
    case (in_data.command)
      plc_pkg::CMD_INS_FRONT: begin
        is_ins = 1'b1;
      end
      plc_pkg::CMD_INS_END: begin
        is_ins = 1'b1;
        lpos   = nx;
      end
      plc_pkg::CMD_INS_AT: begin
        is_ins = 1'b1;
        lpos   = (px > nx) ? nx : px;
      end
      plc_pkg::CMD_DEL_FRONT: begin
        is_del = 1'b1;
      end
      plc_pkg::CMD_DEL_END: begin
        // wraps on an empty list, which then fails the range check
        is_del = 1'b1;
        lpos   = nx - XW'(1);
      end
      plc_pkg::CMD_DEL_AT: begin
        is_del = 1'b1;
        lpos   = px;
      end
      plc_pkg::CMD_REVERSE: begin
        is_rev = 1'b1;
      end
      default: begin
        is_rd = 1'b1;
        lpos  = px;
      end
    endcase
    inb      = (lpos < nx);
    // an insert before position p sits after cell length-1-p when reversed
    phys_ins = rev_r ? (nx - lpos) : lpos;
    phys_hit = rev_r ? (nx - XW'(1) - lpos) : lpos;

    ctl.ins      = accept && is_ins && !full;
    ctl.del      = accept && is_del && inb;
    ctl.rd_load  = accept && is_rd && inb;
    ctl.rd_shift = (state_r == S_READ) && (rd_cnt_r != '0);
    ctl.target   = is_ins ? phys_ins : phys_hit;
    ctl.value    = in_data.value;

    new_len = nx;
    if (ctl.ins) begin
      new_len = nx + XW'(1);
    end else if (ctl.del) begin
      new_len = nx - XW'(1);
    end
  end

  // control, count and result buffer
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    rev_nxt    = rev_r;
    rd_cnt_nxt = rd_cnt_r;
    done       = 1'b0;
    res.status     = plc_pkg::PLC_ST_DONE;
    res.length     = new_len[plc_pkg::PLC_LEN_W-1:0];
    res.read_value = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (ctl.ins) begin
            cnt_nxt = cnt_r + CW'(1);
          end else if (ctl.del) begin
            cnt_nxt = cnt_r - CW'(1);
          end
          if (is_rev) begin
            rev_nxt = !rev_r;
          end
          if (ctl.rd_load) begin
            state_nxt  = S_READ;
            rd_cnt_nxt = phys_hit[IW-1:0];
          end else begin
            done = 1'b1;
            if (is_ins && full) begin
              res.status = plc_pkg::PLC_ST_FULL;
            end else if ((is_del || is_rd) && !inb) begin
              res.status = plc_pkg::PLC_ST_RANGE;
            end
          end
        end
      end
      S_READ: begin
        if (rd_cnt_r == '0) begin
          done           = 1'b1;
          res.read_value = rbus[0];
          state_nxt      = S_IDLE;
        end else begin
          rd_cnt_nxt = rd_cnt_r - IW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    o0_valid_nxt = o0_valid_r && !take;
    o1_valid_nxt = o1_valid_r;
    o0_nxt       = o0_r;
    o1_nxt       = o1_r;
    if (!o0_valid_nxt) begin
      if (o1_valid_r) begin
        o0_valid_nxt = 1'b1;
        o0_nxt       = o1_r;
        o1_valid_nxt = done;
        o1_nxt       = res;
      end else if (done) begin
        o0_valid_nxt = 1'b1;
        o0_nxt       = res;
      end
    end else if (done) begin
      o1_valid_nxt = 1'b1;
      o1_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      rev_r      <= 1'b0;
      rd_cnt_r   <= '0;
      o0_valid_r <= 1'b0;
      o1_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      rev_r      <= rev_nxt;
      rd_cnt_r   <= rd_cnt_nxt;
      o0_valid_r <= o0_valid_nxt;
      o1_valid_r <= o1_valid_nxt;
    end
    o0_r <= o0_nxt;
    o1_r <= o1_nxt;
  end

  a_buf_order: assert property (@(posedge clk) disable iff (!rst_n)
    o1_valid_r |-> o0_valid_r)
    else $error("second result word held with the first slot empty");

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_read_buf: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> !o1_valid_r)
    else $error("read walk started without a free result slot");

  a_ins_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("insert did not grow the count");

  a_rd_walk: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rd_shift |=> (state_r == S_READ) && (rd_cnt_r == $past(rd_cnt_r) - IW'(1)))
    else $error("read walk counter out of step");

endmodule

>>> hdl/plc_cell.sv
module plc_cell #(
  parameter int INDEX = 0
) (
  input  logic                                 clk,
  input  plc_pkg::plc_cell_ctl_t               ctl,
  input  logic signed [plc_pkg::PLC_VAL_W-1:0] left_dat,
  input  logic signed [plc_pkg::PLC_VAL_W-1:0] right_dat,
  input  logic signed [plc_pkg::PLC_VAL_W-1:0] right_rbus,
  output logic signed [plc_pkg::PLC_VAL_W-1:0] dat,
  output logic signed [plc_pkg::PLC_VAL_W-1:0] rbus
);

  localparam logic [plc_pkg::PLC_IDX_W-1:0] IDX = plc_pkg::PLC_IDX_W'(INDEX);

  logic signed [plc_pkg::PLC_VAL_W-1:0] dat_r;
  logic signed [plc_pkg::PLC_VAL_W-1:0] rbus_r;

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      // open a gap at target, everything above moves up one cell
      if (IDX > ctl.target) begin
        dat_r <= left_dat;
      end else if (IDX == ctl.target) begin
        dat_r <= ctl.value;
      end
    end else if (ctl.del) begin
      if (IDX >= ctl.target) begin
        dat_r <= right_dat;
      end
    end
  end

  // read bus: snapshot of the row, then shifts toward cell zero
  always_ff @(posedge clk) begin
    if (ctl.rd_load) begin
      rbus_r <= dat_r;
    end else if (ctl.rd_shift) begin
      rbus_r <= right_rbus;
    end
  end

  assign dat  = dat_r;
  assign rbus = rbus_r;

endmodule
